@@ rtl/core/chord_keyboard_encoder_unit_defines.svh @@
// Assertion macros shared by the chord keyboard encoder checker.
// Needs nothing else; the including file supplies clock and reset names.
`ifndef CHORD_KEYBOARD_ENCODER_UNIT_DEFINES_SVH
`define CHORD_KEYBOARD_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CKE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chord keyboard encoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CKE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chord keyboard encoder: next-cycle check failed");

`endif

@@ rtl/core/cke_pkg.sv @@
// Shared types, constants and key code tables of the chord keyboard encoder.
// Used by every module in rtl/core except cke_checker; depends on nothing.
`default_nettype none

package cke_pkg;

  localparam int TABLE_DEPTH         = 256;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int CHORD_W             = 10;
  localparam int TIME_W              = 32;
  localparam int KEY_W               = 8;
  localparam int MS_W                = 16;
  localparam int CFG_ADDR_W          = 5;
  localparam int CFG_DATA_W          = 32;

  // Register indexes (paddr[4:2]).
  localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [2:0] REG_REPEAT_START = 3'd1;
  localparam logic [2:0] REG_REPEAT_INTVL = 3'd2;
  localparam logic [2:0] REG_CTRL_CODE   = 3'd3;
  localparam logic [2:0] REG_SHIFT_CODE  = 3'd4;
  localparam logic [2:0] REG_ALT_CODE    = 3'd5;

  // Register reset values.
  localparam logic [MS_W-1:0]  DEBOUNCE_RST     = 16'd60;
  localparam logic [MS_W-1:0]  REPEAT_START_RST = 16'd550;
  localparam logic [MS_W-1:0]  REPEAT_INTVL_RST = 16'd20;
  localparam logic [KEY_W-1:0] CTRL_CODE_RST    = 8'd128;
  localparam logic [KEY_W-1:0] SHIFT_CODE_RST   = 8'd129;
  localparam logic [KEY_W-1:0] ALT_CODE_RST     = 8'd130;

  // Thumb bit patterns.
  localparam logic [1:0] THUMB_LEFT  = 2'b01;
  localparam logic [1:0] THUMB_RIGHT = 2'b10;
  localparam logic [1:0] THUMB_BOTH  = 2'b11;

  typedef struct packed {
    logic [CHORD_W-1:0] chord;
    logic [TIME_W-1:0]  now;
  } tick_t;

  typedef struct packed {
    logic [MS_W-1:0]  debounce_ms;
    logic [MS_W-1:0]  repeat_start_ms;
    logic [MS_W-1:0]  repeat_interval_ms;
    logic [KEY_W-1:0] ctrl_code;
    logic [KEY_W-1:0] shift_code;
    logic [KEY_W-1:0] alt_code;
  } cfg_t;

  typedef struct packed {
    logic             press_valid;
    logic             modifier_valid;
    logic [KEY_W-1:0] modifier_code;
    logic [KEY_W-1:0] key_code;
    logic             release_all;
    logic             keypad_active;
  } result_t;

  // Normal mode table: finger bits to ASCII-style key codes.
  function automatic logic [KEY_W-1:0] rom_normal(input logic [KEY_W-1:0] idx);
    logic [KEY_W-1:0] code;
    unique case (idx)
      8'd1:   code = 8'h20;
      8'd2:   code = 8'h65;
      8'd4:   code = 8'h74;
      8'd8:   code = 8'h69;
      8'd16:  code = 8'h72;
      8'd32:  code = 8'h73;
      8'd64:  code = 8'h6E;
      8'd128: code = 8'h61;
      8'd3:   code = 8'h6F;
      8'd5:   code = 8'h6C;
      8'd6:   code = 8'h63;
      8'd9:   code = 8'h30;
      8'd10:  code = 8'h64;
      8'd12:  code = 8'h2E;
      8'd17:  code = 8'h2C;
      8'd18:  code = 8'h75;
      8'd20:  code = 8'h2D;
      8'd24:  code = 8'h28;
      8'd33:  code = 8'h29;
      8'd34:  code = 8'h5F;
      8'd36:  code = 8'h3B;
      8'd40:  code = 8'h70;
      8'd48:  code = 8'h66;
      8'd65:  code = 8'h6D;
      8'd66:  code = 8'h68;
      8'd68:  code = 8'h31;
      8'd72:  code = 8'h62;
      8'd80:  code = 8'h67;
      8'd96:  code = 8'h2F;
      8'd129: code = 8'h6B;
      8'd130: code = 8'h3D;
      8'd132: code = 8'h76;
      8'd136: code = 8'h3A;
      8'd144: code = 8'h32;
      8'd160: code = 8'h77;
      8'd192: code = 8'h79;
      8'd7:   code = 8'h33;
      8'd11:  code = 8'h7B;
      8'd13:  code = 8'h3C;
      8'd14:  code = 8'h22;
      8'd19:  code = 8'h78;
      8'd21:  code = 8'h34;
      8'd22:  code = 8'h7D;
      8'd25:  code = 8'h36;
      8'd26:  code = 8'h35;
      8'd28:  code = 8'h37;
      8'd35:  code = 8'h38;
      8'd37:  code = 8'h7A;
      8'd38:  code = 8'h2A;
      8'd41:  code = 8'h39;
      8'd42:  code = 8'h3E;
      8'd44:  code = 8'h2B;
      8'd49:  code = 8'h5B;
      8'd50:  code = 8'h5D;
      8'd52:  code = 8'h6A;
      8'd56:  code = 8'h71;
      8'd67:  code = 8'h26;
      8'd69:  code = 8'h23;
      8'd70:  code = 8'h5C;
      8'd73:  code = 8'h27;
      8'd74:  code = 8'h21;
      8'd76:  code = 8'h7C;
      8'd81:  code = 8'h25;
      8'd82:  code = 8'h40;
      8'd84:  code = 8'h3F;
      8'd88:  code = 8'h7E;
      8'd97:  code = 8'h24;
      8'd98:  code = 8'h5E;
      8'd100: code = 8'h60;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // Keypad mode table: finger bits to keyboard library key codes.
  function automatic logic [KEY_W-1:0] rom_keypad(input logic [KEY_W-1:0] idx);
    logic [KEY_W-1:0] code;
    unique case (idx)
      8'd1:  code = 8'h80;
      8'd2:  code = 8'h81;
      8'd4:  code = 8'h82;
      8'd8:  code = 8'h83;
      8'd16: code = 8'h84;
      8'd32: code = 8'h85;
      8'd3:  code = 8'h86;
      8'd5:  code = 8'h87;
      8'd6:  code = 8'hDA;
      8'd9:  code = 8'hD9;
      8'd10: code = 8'hD8;
      8'd12: code = 8'hD7;
      8'd17: code = 8'hB2;
      8'd18: code = 8'hB3;
      8'd20: code = 8'hB0;
      8'd24: code = 8'hB1;
      8'd33: code = 8'hD1;
      8'd34: code = 8'hD4;
      8'd36: code = 8'hD3;
      8'd40: code = 8'hD6;
      8'd48: code = 8'hD2;
      8'd7:  code = 8'hD5;
      8'd11: code = 8'hC1;
      8'd13: code = 8'hC2;
      8'd14: code = 8'hC3;
      8'd19: code = 8'hC4;
      8'd21: code = 8'hC5;
      8'd22: code = 8'hC6;
      8'd25: code = 8'hC7;
      8'd26: code = 8'hC8;
      8'd28: code = 8'hC9;
      8'd35: code = 8'hCA;
      8'd37: code = 8'hCB;
      8'd38: code = 8'hCC;
      8'd41: code = 8'hCD;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cke_front.sv @@
// Front end of the chord keyboard encoder: debounces raw button ticks.
// Depends on cke_pkg; feeds cke_queue with the stable chord and timestamp.
`default_nettype none

module cke_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [cke_pkg::CHORD_W-1:0] raw,
  input  wire logic [cke_pkg::TIME_W-1:0]  now,
  input  wire logic [cke_pkg::MS_W-1:0]    debounce_ms,
  output cke_pkg::tick_t                   item
);

  logic [cke_pkg::CHORD_W-1:0] raw_previous, raw_previous_next;
  logic [cke_pkg::TIME_W-1:0]  raw_change_time, raw_change_time_next;
  logic [cke_pkg::CHORD_W-1:0] stable_chord, stable_chord_next;
  logic [cke_pkg::TIME_W-1:0]  elapsed;
  logic [cke_pkg::TIME_W-1:0]  debounce_wide;

  assign debounce_wide = {{(cke_pkg::TIME_W-cke_pkg::MS_W){1'b0}}, debounce_ms};
  assign elapsed       = now - raw_change_time;

  always_comb begin
    raw_previous_next    = raw_previous;
    raw_change_time_next = raw_change_time;
    stable_chord_next    = stable_chord;
    if (raw == raw_previous) begin
      // Pin the change time just past the window so it never wraps back in.
      if (elapsed > debounce_wide) begin
        raw_change_time_next = now - debounce_wide - 32'd1;
        stable_chord_next    = raw;
      end
    end else begin
      raw_previous_next    = raw;
      raw_change_time_next = now;
    end
  end

  assign item.chord = stable_chord_next;
  assign item.now   = now;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_previous    <= '0;
      raw_change_time <= '0;
      stable_chord    <= '0;
    end else if (accept) begin
      raw_previous    <= raw_previous_next;
      raw_change_time <= raw_change_time_next;
      stable_chord    <= stable_chord_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cke_queue.sv @@
// Short FIFO between the debounce front end and the send logic back end.
// Depends on cke_pkg for the entry type.
`default_nettype none

module cke_queue #(
  parameter int DEPTH = cke_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cke_pkg::tick_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output cke_pkg::tick_t      head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cke_pkg::tick_t slots [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cke_back.sv @@
// Back end of the chord keyboard encoder: mode toggle, autorepeat, key lookup.
// Depends on cke_pkg; drains cke_queue into a registered result stage.
`default_nettype none

module cke_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cke_pkg::cfg_t  cfg,
  input  wire logic           head_valid,
  input  wire cke_pkg::tick_t head,
  output logic                pop,
  output logic                result_valid,
  input  wire logic           result_ready,
  output cke_pkg::result_t    result
);

  logic [cke_pkg::CHORD_W-1:0] sent_chord, sent_chord_next;
  logic [cke_pkg::TIME_W-1:0]  send_time, send_time_next;
  logic                        repeating, repeating_next;
  logic                        keypad_mode, keypad_mode_next;
  logic                        send_now;
  logic [cke_pkg::KEY_W-1:0]   fingers;
  logic [1:0]                  thumbs;
  logic [cke_pkg::TIME_W-1:0]  held;
  cke_pkg::result_t            res;

  assign fingers = head.chord[cke_pkg::KEY_W-1:0];
  assign thumbs  = head.chord[cke_pkg::CHORD_W-1:cke_pkg::KEY_W];
  assign held    = head.now - send_time;
  assign pop     = head_valid && (!result_valid || result_ready);

  always_comb begin
    sent_chord_next  = sent_chord;
    send_time_next   = send_time;
    repeating_next   = repeating;
    keypad_mode_next = keypad_mode;
    send_now         = 1'b1;
    res              = '0;
    if (fingers == '0 && thumbs != 2'b00) begin
      // A new thumbs-only chord flips the mode; holding it does nothing more.
      if (head.chord != sent_chord) begin
        keypad_mode_next = !keypad_mode;
        sent_chord_next  = head.chord;
        send_time_next   = head.now;
        res.release_all  = 1'b1;
      end
    end else if (head.chord == '0) begin
      sent_chord_next = '0;
      send_time_next  = head.now;
      res.release_all = 1'b1;
    end else begin
      if (head.chord == sent_chord) begin
        if (repeating) begin
          if (held < {16'd0, cfg.repeat_interval_ms}) begin
            send_now = 1'b0;
          end
        end else if (held < {16'd0, cfg.repeat_start_ms}) begin
          send_now = 1'b0;
        end else begin
          repeating_next = 1'b1;
        end
      end else begin
        repeating_next = 1'b0;
      end
      if (send_now) begin
        send_time_next  = head.now;
        sent_chord_next = head.chord;
        res.press_valid = 1'b1;
        res.key_code    = keypad_mode ? cke_pkg::rom_keypad(fingers)
                                      : cke_pkg::rom_normal(fingers);
        unique case (thumbs)
          cke_pkg::THUMB_BOTH: begin
            res.modifier_valid = 1'b1;
            res.modifier_code  = cfg.alt_code;
          end
          cke_pkg::THUMB_LEFT: begin
            res.modifier_valid = 1'b1;
            res.modifier_code  = cfg.ctrl_code;
          end
          cke_pkg::THUMB_RIGHT: begin
            res.modifier_valid = 1'b1;
            res.modifier_code  = cfg.shift_code;
          end
          default: begin
            res.modifier_valid = 1'b0;
          end
        endcase
      end
      res.release_all = 1'b1;
    end
    res.keypad_active = keypad_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_chord   <= '0;
      send_time    <= '0;
      repeating    <= 1'b0;
      keypad_mode  <= 1'b0;
      result_valid <= 1'b0;
    end else if (pop) begin
      sent_chord   <= sent_chord_next;
      send_time    <= send_time_next;
      repeating    <= repeating_next;
      keypad_mode  <= keypad_mode_next;
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/chord_keyboard_encoder_unit.sv @@
// Chord keyboard encoder: each tick carries ten button bits and a millisecond
// timestamp and yields exactly one result (press, modifier, key, release, mode).
// Ticks enter on tick_valid/tick_ready and results leave on
// result_valid/result_ready; a request is taken when valid and ready are high.
// The debounce front end takes one tick per cycle, while the queue is not full,
// into a QUEUE_DEPTH-entry queue; the back end takes one queue entry per cycle,
// unless a result waits untaken, into the result register. An accepted tick is
// written into the queue, and its result is registered from the queue head.
// When the receiver stalls, the result register holds and the queue fills;
// tick_ready drops only when the queue is full, and QUEUE_DEPTH ticks plus one
// result can wait in the block.
// Synchronous reset clears the debounce and send state, empties the queue, returns
// to normal mode and loads the register defaults (60, 550, 20, 128, 129, 130).
// The user must write registers over the APB-style port only while idle; the
// block does not enforce it. Depends on cke_pkg, cke_front, cke_queue and cke_back.
`default_nettype none

module chord_keyboard_encoder_unit #(
  parameter int QUEUE_DEPTH = cke_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           tick_valid,
  output logic                                tick_ready,
  input  wire logic [cke_pkg::CHORD_W-1:0]    buttons_pressed,
  input  wire logic [cke_pkg::TIME_W-1:0]     now_ms,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output logic                                press_valid,
  output logic                                modifier_valid,
  output logic [cke_pkg::KEY_W-1:0]           modifier_code,
  output logic [cke_pkg::KEY_W-1:0]           key_code,
  output logic                                release_all,
  output logic                                keypad_active,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cke_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [cke_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cke_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  cke_pkg::cfg_t    cfg;
  cke_pkg::tick_t   front_item;
  cke_pkg::tick_t   head;
  cke_pkg::result_t result;
  logic             queue_full;
  logic             head_valid;
  logic             pop;
  logic             tick_accept;
  logic             cfg_write;
  logic [2:0]       reg_index;

  assign pready      = 1'b1;
  assign reg_index   = paddr[4:2];
  assign cfg_write   = psel && penable && pwrite && pready;
  assign tick_ready  = !queue_full;
  assign tick_accept = tick_valid && tick_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms        <= cke_pkg::DEBOUNCE_RST;
      cfg.repeat_start_ms    <= cke_pkg::REPEAT_START_RST;
      cfg.repeat_interval_ms <= cke_pkg::REPEAT_INTVL_RST;
      cfg.ctrl_code          <= cke_pkg::CTRL_CODE_RST;
      cfg.shift_code         <= cke_pkg::SHIFT_CODE_RST;
      cfg.alt_code           <= cke_pkg::ALT_CODE_RST;
    end else if (cfg_write) begin
      case (reg_index)
        cke_pkg::REG_DEBOUNCE:     cfg.debounce_ms        <= pwdata[15:0];
        cke_pkg::REG_REPEAT_START: cfg.repeat_start_ms    <= pwdata[15:0];
        cke_pkg::REG_REPEAT_INTVL: cfg.repeat_interval_ms <= pwdata[15:0];
        cke_pkg::REG_CTRL_CODE:    cfg.ctrl_code          <= pwdata[7:0];
        cke_pkg::REG_SHIFT_CODE:   cfg.shift_code         <= pwdata[7:0];
        cke_pkg::REG_ALT_CODE:     cfg.alt_code           <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      cke_pkg::REG_DEBOUNCE:     prdata = {16'd0, cfg.debounce_ms};
      cke_pkg::REG_REPEAT_START: prdata = {16'd0, cfg.repeat_start_ms};
      cke_pkg::REG_REPEAT_INTVL: prdata = {16'd0, cfg.repeat_interval_ms};
      cke_pkg::REG_CTRL_CODE:    prdata = {24'd0, cfg.ctrl_code};
      cke_pkg::REG_SHIFT_CODE:   prdata = {24'd0, cfg.shift_code};
      cke_pkg::REG_ALT_CODE:     prdata = {24'd0, cfg.alt_code};
      default:                   prdata = '0;
    endcase
  end

  cke_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (tick_accept),
    .raw         (buttons_pressed),
    .now         (now_ms),
    .debounce_ms (cfg.debounce_ms),
    .item        (front_item)
  );

  cke_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (tick_accept),
    .push_data  (front_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head)
  );

  cke_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  assign press_valid    = result.press_valid;
  assign modifier_valid = result.modifier_valid;
  assign modifier_code  = result.modifier_code;
  assign key_code       = result.key_code;
  assign release_all    = result.release_all;
  assign keypad_active  = result.keypad_active;

endmodule

`default_nettype wire

@@ rtl/core/cke_checker.sv @@
// Port-level checks on the chord keyboard encoder result channel.
// Depends on chord_keyboard_encoder_unit_defines.svh; bound to the top level.
`default_nettype none

`include "chord_keyboard_encoder_unit_defines.svh"

module cke_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       result_valid,
  input wire logic       result_ready,
  input wire logic       press_valid,
  input wire logic       modifier_valid,
  input wire logic [7:0] modifier_code,
  input wire logic [7:0] key_code,
  input wire logic       release_all
);

  // A stalled result keeps its key code until taken.
  `CKE_ASSERT_NEXT(a_hold_key, clk, rst, result_valid && !result_ready, result_valid && $stable(key_code))

  // Without a press, no key or modifier is reported.
  `CKE_ASSERT_NOW(a_idle_quiet, clk, rst, result_valid && !press_valid, key_code == 8'd0 && !modifier_valid)

  // Every press ends with all keys released.
  `CKE_ASSERT_NOW(a_press_release, clk, rst, result_valid && press_valid, release_all)

  // A modifier code only appears alongside its valid flag.
  `CKE_ASSERT_NOW(a_mod_code, clk, rst, result_valid && !modifier_valid, modifier_code == 8'd0)

endmodule

bind chord_keyboard_encoder_unit cke_checker u_cke_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .press_valid    (press_valid),
  .modifier_valid (modifier_valid),
  .modifier_code  (modifier_code),
  .key_code       (key_code),
  .release_all    (release_all)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for chord_keyboard_encoder_unit: every accepted tick is
// run through a behavioral predictor and each result is compared field by field.
// Depends on cke_pkg and the RTL under rtl/core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cke_pkg::*;

  localparam int unsigned LIMIT = 400_000;
  localparam logic [2:0] REG_UNUSED = 3'd6;

  class keystroke_scoreboard;
    cfg_t regs;
    logic [KEY_W-1:0] normal_codes [TABLE_DEPTH];
    logic [KEY_W-1:0] keypad_codes [TABLE_DEPTH];
    logic [CHORD_W-1:0] last_raw, stable, sent;
    logic [TIME_W-1:0] raw_since, sent_at;
    bit autorepeat, keypad;
    result_t pending [$];
    int unsigned errors;

    function new();
      regs = '{DEBOUNCE_RST, REPEAT_START_RST, REPEAT_INTVL_RST,
               CTRL_CODE_RST, SHIFT_CODE_RST, ALT_CODE_RST};
      last_raw = '0; stable = '0; sent = '0; raw_since = '0; sent_at = '0;
      autorepeat = 0; keypad = 0; errors = 0;
      foreach (normal_codes[i]) begin
        normal_codes[i] = '0;
        keypad_codes[i] = '0;
      end
      normal_codes[1] = " ";   normal_codes[2] = "e";   normal_codes[4] = "t";
      normal_codes[8] = "i";   normal_codes[16] = "r";  normal_codes[32] = "s";
      normal_codes[64] = "n";  normal_codes[128] = "a"; normal_codes[3] = "o";
      normal_codes[5] = "l";   normal_codes[6] = "c";   normal_codes[9] = "0";
      normal_codes[10] = "d";  normal_codes[12] = ".";  normal_codes[17] = ",";
      normal_codes[18] = "u";  normal_codes[20] = "-";  normal_codes[24] = "(";
      normal_codes[33] = ")";  normal_codes[34] = "_";  normal_codes[36] = ";";
      normal_codes[40] = "p";  normal_codes[48] = "f";  normal_codes[65] = "m";
      normal_codes[66] = "h";  normal_codes[68] = "1";  normal_codes[72] = "b";
      normal_codes[80] = "g";  normal_codes[96] = "/";  normal_codes[129] = "k";
      normal_codes[130] = "="; normal_codes[132] = "v"; normal_codes[136] = ":";
      normal_codes[144] = "2"; normal_codes[160] = "w"; normal_codes[192] = "y";
      normal_codes[7] = "3";   normal_codes[11] = "{";  normal_codes[13] = "<";
      normal_codes[14] = "\""; normal_codes[19] = "x";  normal_codes[21] = "4";
      normal_codes[22] = "}";  normal_codes[25] = "6";  normal_codes[26] = "5";
      normal_codes[28] = "7";  normal_codes[35] = "8";  normal_codes[37] = "z";
      normal_codes[38] = "*";  normal_codes[41] = "9";  normal_codes[42] = ">";
      normal_codes[44] = "+";  normal_codes[49] = "[";  normal_codes[50] = "]";
      normal_codes[52] = "j";  normal_codes[56] = "q";  normal_codes[67] = "&";
      normal_codes[69] = "#";  normal_codes[70] = "\\"; normal_codes[73] = "'";
      normal_codes[74] = "!";  normal_codes[76] = "|";  normal_codes[81] = "%";
      normal_codes[82] = "@";  normal_codes[84] = "?";  normal_codes[88] = "~";
      normal_codes[97] = "$";  normal_codes[98] = "^";  normal_codes[100] = 8'h60;
      keypad_codes[1] = 8'h80;  keypad_codes[2] = 8'h81;  keypad_codes[4] = 8'h82;
      keypad_codes[8] = 8'h83;  keypad_codes[16] = 8'h84; keypad_codes[32] = 8'h85;
      keypad_codes[3] = 8'h86;  keypad_codes[5] = 8'h87;  keypad_codes[6] = 8'hDA;
      keypad_codes[9] = 8'hD9;  keypad_codes[10] = 8'hD8; keypad_codes[12] = 8'hD7;
      keypad_codes[17] = 8'hB2; keypad_codes[18] = 8'hB3; keypad_codes[20] = 8'hB0;
      keypad_codes[24] = 8'hB1; keypad_codes[33] = 8'hD1; keypad_codes[34] = 8'hD4;
      keypad_codes[36] = 8'hD3; keypad_codes[40] = 8'hD6; keypad_codes[48] = 8'hD2;
      keypad_codes[7] = 8'hD5;  keypad_codes[11] = 8'hC1; keypad_codes[13] = 8'hC2;
      keypad_codes[14] = 8'hC3; keypad_codes[19] = 8'hC4; keypad_codes[21] = 8'hC5;
      keypad_codes[22] = 8'hC6; keypad_codes[25] = 8'hC7; keypad_codes[26] = 8'hC8;
      keypad_codes[28] = 8'hC9; keypad_codes[35] = 8'hCA; keypad_codes[37] = 8'hCB;
      keypad_codes[38] = 8'hCC; keypad_codes[41] = 8'hCD;
    endfunction

    function void set_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_DEBOUNCE:     regs.debounce_ms = value[MS_W-1:0];
        REG_REPEAT_START: regs.repeat_start_ms = value[MS_W-1:0];
        REG_REPEAT_INTVL: regs.repeat_interval_ms = value[MS_W-1:0];
        REG_CTRL_CODE:    regs.ctrl_code = value[KEY_W-1:0];
        REG_SHIFT_CODE:   regs.shift_code = value[KEY_W-1:0];
        REG_ALT_CODE:     regs.alt_code = value[KEY_W-1:0];
        default: ;
      endcase
    endfunction

    // Debounce the raw chord, then decide between mode toggle, release and key press.
    function void take_tick(logic [CHORD_W-1:0] raw, logic [TIME_W-1:0] now);
      result_t want;
      logic [KEY_W-1:0] fingers;
      logic [1:0] thumbs;
      bit fire;
      want = '0;
      if (raw == last_raw) begin
        if (now - raw_since > TIME_W'(regs.debounce_ms)) begin
          raw_since = now - TIME_W'(regs.debounce_ms) - 1;
          stable = raw;
        end
      end else begin
        last_raw = raw;
        raw_since = now;
      end
      fingers = stable[7:0];
      thumbs = stable[9:8];
      if (fingers == 0 && thumbs != 0) begin
        if (stable != sent) begin
          keypad = !keypad;
          sent = stable;
          sent_at = now;
          want.release_all = 1'b1;
        end
      end else if (stable == 0) begin
        sent = '0;
        sent_at = now;
        want.release_all = 1'b1;
      end else begin
        fire = 1;
        if (stable == sent) begin
          if (autorepeat) fire = (now - sent_at) >= TIME_W'(regs.repeat_interval_ms);
          else if ((now - sent_at) < TIME_W'(regs.repeat_start_ms)) fire = 0;
          else autorepeat = 1;
        end else begin
          autorepeat = 0;
        end
        if (fire) begin
          sent_at = now;
          sent = stable;
          want.press_valid = 1'b1;
          want.key_code = keypad ? keypad_codes[fingers] : normal_codes[fingers];
          want.modifier_valid = (thumbs != 0);
          case (thumbs)
            THUMB_BOTH:  want.modifier_code = regs.alt_code;
            THUMB_LEFT:  want.modifier_code = regs.ctrl_code;
            THUMB_RIGHT: want.modifier_code = regs.shift_code;
            default: ;
          endcase
        end
        want.release_all = 1'b1;
      end
      want.keypad_active = keypad;
      pending.push_back(want);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_keystroke(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("result request arrived with no tick waiting for it");
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("press_valid", want.press_valid, got.press_valid);
      compare("modifier_valid", want.modifier_valid, got.modifier_valid);
      compare("modifier_code", want.modifier_code, got.modifier_code);
      compare("key_code", want.key_code, got.key_code);
      compare("release_all", want.release_all, got.release_all);
      compare("keypad_active", want.keypad_active, got.keypad_active);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic tick_valid = 1'b0;
  logic tick_ready;
  logic [CHORD_W-1:0] buttons_pressed = '0;
  logic [TIME_W-1:0] now_ms = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic press_valid, modifier_valid, release_all, keypad_active;
  logic [KEY_W-1:0] modifier_code, key_code;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  keystroke_scoreboard sb = new();
  logic [TIME_W-1:0] wall_ms = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned ticks_sent = 0;
  int unsigned cycle_count;

  chord_keyboard_encoder_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (cycle_count = 0; cycle_count < LIMIT; cycle_count++) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && tick_valid && tick_ready) sb.take_tick(buttons_pressed, now_ms);
    if (!rst && result_valid && result_ready)
      sb.check_keystroke({press_valid, modifier_valid, modifier_code, key_code,
                          release_all, keypad_active});
  end

  task automatic send_tick(input logic [CHORD_W-1:0] chord);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    buttons_pressed <= chord;
    now_ms <= wall_ms;
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Stop sending and wait until every predicted result has been checked.
  task automatic drain();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // Upper data bits are random so that the register width is exercised too.
  task automatic apply_config(input logic [MS_W-1:0] deb, rs, ri,
                              input logic [KEY_W-1:0] ctl, sft, alt);
    drain();
    write_reg(REG_DEBOUNCE, {16'($urandom), deb});
    write_reg(REG_REPEAT_START, {16'($urandom), rs});
    write_reg(REG_REPEAT_INTVL, {16'($urandom), ri});
    write_reg(REG_CTRL_CODE, {24'($urandom), ctl});
    write_reg(REG_SHIFT_CODE, {24'($urandom), sft});
    write_reg(REG_ALT_CODE, {24'($urandom), alt});
  endtask

  // Time steps are scaled to the current debounce and repeat settings.
  function automatic int unsigned step_limit();
    int unsigned deb, rs, ri;
    deb = sb.regs.debounce_ms;
    rs = sb.regs.repeat_start_ms;
    ri = sb.regs.repeat_interval_ms;
    case ($urandom_range(0, 4))
      0: return deb / 2 + 1;
      1: return deb + 2;
      2: return ri + 2;
      3: return rs / 4 + 2;
      default: return 2 * (deb + rs) + 2;
    endcase
  endfunction

  function automatic logic [CHORD_W-1:0] key_chord();
    logic [KEY_W-1:0] f;
    f = KEY_W'($urandom_range(1, 255));
    // Lean toward finger patterns that have a code in the normal table.
    repeat (4) if (sb.normal_codes[f] == 0) f = KEY_W'($urandom_range(1, 255));
    return {2'($urandom_range(0, 3)), f};
  endfunction

  task automatic hold_chord(input logic [CHORD_W-1:0] chord, input int unsigned ticks);
    int unsigned limit;
    limit = step_limit();
    repeat (ticks) begin
      send_tick(chord);
      wall_ms += $urandom_range(0, limit);
    end
  endtask

  task automatic noise_ticks(input int unsigned ticks, input int unsigned limit);
    repeat (ticks) begin
      send_tick(CHORD_W'($urandom));
      wall_ms += $urandom_range(0, limit);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop, pick;
    stop = ticks_sent + count;
    while (ticks_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // Contact bounce, a held key chord, then usually a release.
        noise_ticks($urandom_range(0, 3), 3);
        hold_chord(key_chord(), $urandom_range(2, 16));
        if ($urandom_range(0, 2) != 0) hold_chord('0, $urandom_range(1, 6));
      end else if (pick < 80) begin
        hold_chord({2'($urandom_range(1, 3)), 8'h00}, $urandom_range(2, 8));
      end else if (pick < 95) begin
        noise_ticks($urandom_range(1, 5), step_limit());
      end else begin
        wall_ms = $urandom();
      end
    end
  endtask

  task automatic run_directed();
    tick_t plan [24];
    plan = '{
      '{10'h001, 32'd1000}, '{10'h001, 32'd1061}, '{10'h001, 32'd1100},
      '{10'h001, 32'd1700}, '{10'h001, 32'd1710}, '{10'h001, 32'd1730},
      '{10'h000, 32'd1731}, '{10'h000, 32'd1800}, '{10'h100, 32'd1801},
      '{10'h100, 32'd1900}, '{10'h100, 32'd1950}, '{10'h301, 32'd1951},
      '{10'h301, 32'd2100}, '{10'h2FF, 32'd2101}, '{10'h2FF, 32'd2200},
      '{10'h103, 32'd2201}, '{10'h103, 32'd2300}, '{10'h200, 32'd2301},
      '{10'h200, 32'd2400}, '{10'h3FF, 32'hFFFF_FFF0}, '{10'h3FF, 32'h0000_0030},
      '{10'h000, 32'hFFFF_FFFF}, '{10'h000, 32'h0000_0000}, '{10'h000, 32'h0000_0040}
    };
    foreach (plan[i]) begin
      wall_ms = plan[i].now;
      send_tick(plan[i].chord);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    wall_ms = $urandom();
    run_random(150);

    apply_config(16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
    write_reg(REG_UNUSED, $urandom());
    send_idle_pct = 77;
    run_random(150);

    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_idle_pct = 0;
    recv_stall_pct = 77;
    run_random(150);

    apply_config(16'($urandom_range(0, 200)), 16'($urandom_range(0, 1000)),
                 16'($urandom_range(0, 100)), 8'($urandom), 8'($urandom), 8'($urandom));
    send_idle_pct = 34;
    recv_stall_pct = 34;
    run_random(75);
    drain();
    run_random(75);

    apply_config(16'($urandom), 16'($urandom), 16'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(150);

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ chord_keyboard_encoder_unit.f @@
+incdir+rtl/core
rtl/core/cke_pkg.sv
rtl/core/cke_front.sv
rtl/core/cke_queue.sv
rtl/core/cke_back.sv
rtl/core/chord_keyboard_encoder_unit.sv
rtl/core/cke_checker.sv
tb/sv/testbench.sv
